// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Each macro checks a property on the rising edge of the given clock and is
// switched off while the given active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define SVA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define SVA_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SVA_ASSERT(label, clk, rst_n, prop, msg)
`define SVA_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== design/sva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sva_pkg;

	// Default sizes of the array and of each entry's history.
	localparam int ENTRIES_DEF    = 64;
	localparam int HIST_DEPTH_DEF = 16;

	// Field widths fixed by the item formats.
	localparam int REQ_W   = 2;
	localparam int INDEX_W = 6;
	localparam int VALUE_W = 32;
	localparam int SNAP_W  = 16;
	localparam int LEN_W   = 7;
	localparam int STAT_W  = 2;

	localparam logic [LEN_W-1:0]  LEN_RESET = 7'd64;
	localparam logic [SNAP_W-1:0] SNAP_MAX  = 16'hFFFF;

	// Request kinds.
	typedef enum logic [REQ_W-1:0] {
		REQ_SET  = 2'd0,
		REQ_SNAP = 2'd1,
		REQ_GET  = 2'd2,
		REQ_NONE = 2'd3
	} req_kind_t;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd3;

	// Request item.
	typedef struct packed {
		logic [REQ_W-1:0]          req_type;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
		logic [SNAP_W-1:0]         snap_id;
	} req_t;

	// Result item.
	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [SNAP_W-1:0]         snap_taken;
		logic [STAT_W-1:0]         status;
	} rsp_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CNT_RD,
		ST_CNT_DATA,
		ST_SET_CHK,
		ST_SRCH,
		ST_CMP,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// ===== design/sva_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Valid/ready channel carrying one item of type T per handshake.
interface sva_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sva_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module sva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/snapshot_versioned_array.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Versioned array with snapshots.
// req carries request items (set, snap, get); rsp returns exactly one result
// item per request, in order. cfg_we/cfg_wdata write the number of entries in
// use, and may only be written while the block is idle.
// Each entry keeps a history of (snapshot id, value) pairs in one shared
// history RAM; a per-entry pair count sits in a second RAM. A small sequencer
// drives a single compare unit over registered RAM reads.
// Path from acceptance to the result being offered on rsp:
//   snap, unused kinds and rejected indices: count read, then the result;
//   set: count read, then the pair write on an empty history; otherwise a
//   read of the last pair, then the write or a full status;
//   get: count read, then k search steps, k at most ceil(log2(n+1)) for a
//   history of n pairs, each step one history RAM read and a compare.
// req.ready is high only when idle, i.e. once the last result is loaded.
// After reset the block clears the count RAM, one entry per cycle, up to
// entry ENTRIES-1 before it accepts the first item; configuration writes are
// taken throughout. A finished result waits in an output register; while
// rsp is stalled the block still accepts and works on the next item, and
// holds its result until the register is free.
module snapshot_versioned_array #(
	parameter int ENTRIES       = sva_pkg::ENTRIES_DEF,
	parameter int HISTORY_DEPTH = sva_pkg::HIST_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [sva_pkg::LEN_W-1:0] cfg_wdata,
	sva_stream_if.sink                    req,
	sva_stream_if.source                  rsp
);

	import sva_pkg::*;

	// Address widths: entry number, position in a history, pair count.
	localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNTW    = $clog2(HISTORY_DEPTH + 1);
	localparam int HIST_W  = SNAP_W + VALUE_W;
	localparam logic [12:0]     ENTRIES_L = 13'(ENTRIES);
	localparam logic [CNTW-1:0] DEPTH_L   = CNTW'(HISTORY_DEPTH);
	localparam logic [EW-1:0]   LAST_ENT  = EW'(ENTRIES - 1);

	state_t state_q, state_d;

	logic [EW-1:0]     clr_q;
	logic [LEN_W-1:0]  len_q;
	logic [SNAP_W-1:0] snap_q;
	logic              out_valid_q;
	rsp_t              out_q;

	req_t              item_q;
	logic [CNTW-1:0]   n_q, lo_q, hi_q;
	logic [VALUE_W-1:0] val_q;
	rsp_t              res_q;

	// RAM ports.
	logic              cnt_we, cnt_re;
	logic [EW-1:0]     cnt_waddr, cnt_raddr;
	logic [CNTW-1:0]   cnt_wdata, cnt_rdata;
	logic              hist_we, hist_re;
	logic [EW+PW-1:0]  hist_waddr, hist_raddr;
	logic [HIST_W-1:0] hist_wdata, hist_rdata;

	logic              out_load;

	// Decode of the held item.
	req_kind_t         kind;
	logic [EW+5:0]     idx_wide;
	logic [EW-1:0]     entry;
	logic              in_range;
	logic [CNTW-1:0]   mid;
	logic [CNTW-1:0]   last_pos;
	logic [SNAP_W-1:0] rd_id;
	logic [VALUE_W-1:0] rd_val;
	logic              id_le_want;

	assign kind       = req_kind_t'(item_q.req_type);
	assign idx_wide   = (EW + 6)'(item_q.index);
	assign entry      = idx_wide[EW-1:0];
	assign in_range   = ({1'b0, item_q.index} < len_q) && (13'(item_q.index) < ENTRIES_L);
	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign last_pos   = n_q - CNTW'(1);
	assign rd_id      = hist_rdata[HIST_W-1:VALUE_W];
	assign rd_val     = hist_rdata[VALUE_W-1:0];
	assign id_le_want = (rd_id <= item_q.snap_id);

	// Pair counts per entry.
	sva_ram #(
		.WIDTH (CNTW),
		.DEPTH (2 ** EW)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// History pairs, one row of 2**PW positions per entry.
	sva_ram #(
		.WIDTH (HIST_W),
		.DEPTH (2 ** (EW + PW))
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ENT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_CNT_RD;
				end
			end
			ST_CNT_RD: begin
				if ((kind == REQ_SET || kind == REQ_GET) && in_range) begin
					state_d = ST_CNT_DATA;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_CNT_DATA: begin
				if (kind == REQ_GET) begin
					state_d = ST_SRCH;
				end else if (cnt_rdata == '0) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_SET_CHK;
				end
			end
			ST_SET_CHK: state_d = ST_RESP;
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					state_d = ST_CMP;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_CMP: state_d = ST_SRCH;
			ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: RAM controls, handshake and result load.
	always_comb begin
		req.ready  = 1'b0;
		cnt_we     = 1'b0;
		cnt_waddr  = entry;
		cnt_wdata  = '0;
		cnt_re     = 1'b0;
		cnt_raddr  = entry;
		hist_we    = 1'b0;
		hist_waddr = {entry, PW'(n_q)};
		hist_wdata = {snap_q, item_q.value};
		hist_re    = 1'b0;
		hist_raddr = {entry, PW'(mid)};
		out_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
			end
			ST_IDLE: req.ready = 1'b1;
			ST_CNT_RD: cnt_re = 1'b1;
			ST_CNT_DATA: begin
				if (kind == REQ_SET) begin
					if (cnt_rdata == '0) begin
						// Empty history: first pair goes in at position zero.
						hist_we    = 1'b1;
						hist_waddr = {entry, PW'(0)};
						cnt_we     = 1'b1;
						cnt_wdata  = CNTW'(1);
					end else begin
						// Fetch the last pair to see whether it has the current id.
						hist_re    = 1'b1;
						hist_raddr = {entry, PW'(cnt_rdata - CNTW'(1))};
					end
				end
			end
			ST_SET_CHK: begin
				if (rd_id == snap_q) begin
					hist_we    = 1'b1;
					hist_waddr = {entry, PW'(last_pos)};
				end else if (n_q < DEPTH_L) begin
					hist_we   = 1'b1;
					cnt_we    = 1'b1;
					cnt_wdata = n_q + CNTW'(1);
				end
			end
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					hist_re = 1'b1;
				end
			end
			ST_RESP: out_load = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			len_q       <= LEN_RESET;
			snap_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + EW'(1);
			end
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (state_q == ST_CNT_RD && kind == REQ_SNAP && snap_q != SNAP_MAX) begin
				snap_q <= snap_q + SNAP_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, search and result registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_q <= req.data;
		end
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			ST_CNT_RD: begin
				res_q.read_value <= '0;
				res_q.snap_taken <= (kind == REQ_SNAP) ? snap_q : '0;
				if (kind == REQ_SNAP && snap_q == SNAP_MAX) begin
					res_q.status <= STAT_LIMIT;
				end else if ((kind == REQ_SET || kind == REQ_GET) && !in_range) begin
					res_q.status <= STAT_RANGE;
				end else begin
					res_q.status <= STAT_OK;
				end
			end
			ST_CNT_DATA: begin
				n_q   <= cnt_rdata;
				lo_q  <= '0;
				hi_q  <= cnt_rdata;
				val_q <= '0;
			end
			ST_SET_CHK: begin
				if (rd_id != snap_q && n_q >= DEPTH_L) begin
					res_q.status <= STAT_FULL;
				end
			end
			ST_SRCH: begin
				if (lo_q >= hi_q) begin
					res_q.read_value <= val_q;
				end
			end
			ST_CMP: begin
				// The pair just below lo is always the last one read with id at or below.
				if (id_le_want) begin
					lo_q  <= mid + CNTW'(1);
					val_q <= rd_val;
				end else begin
					hi_q <= mid;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// A count written by a set is never zero and never beyond the history depth.
	`SVA_ASSERT(a_cnt_bound, clk, arst_n, (cnt_we && state_q != ST_CLEAR) |-> (cnt_wdata != '0 && cnt_wdata <= DEPTH_L), "pair count write out of bounds")
	// The search window never inverts.
	`SVA_ASSERT(a_srch_window, clk, arst_n, (state_q == ST_SRCH || state_q == ST_CMP) |-> (lo_q <= hi_q), "search window inverted")
	// A result is never loaded over one that is still waiting.
	`SVA_NEVER(a_no_overwrite, clk, arst_n, out_load && out_valid_q && !rsp.ready, "pending result overwritten")
	// The snapshot id only moves forward.
	`SVA_ASSERT(a_snap_mono, clk, arst_n, (state_q != ST_CLEAR) |=> (snap_q >= $past(snap_q)), "snapshot id went backwards")

endmodule

`default_nettype wire
